[rtl/core/lfba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lfba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF       = 4096;
  localparam int unsigned MAX_RUN_DEF          = 64;
  localparam int unsigned FIRST_DATA_BLOCK_DEF = 2;

  localparam int unsigned CFG_W  = 13;
  localparam int unsigned BLK_W  = 12;
  localparam int unsigned RUN_W  = 7;
  localparam int unsigned FREE_W = 12;

  localparam logic [CFG_W-1:0] TOTAL_RESET = 13'd4096;

  typedef enum logic [1:0] {
    OP_FORMAT  = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FORMAT,
    S_POP_RD,
    S_POP_OUT,
    S_REPLY
  } state_e;

endpackage

`default_nettype wire

[rtl/core/lfba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfba_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/linked_free_block_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Free-list block allocator. Free blocks form a singly linked list held in one
// next-link RAM (registered read), with a head and a free count in flip-flops.
// Requests enter only while the sequencer is idle; a finished result waits in
// the output register while the next request is taken. Allocate of n blocks
// takes the request, then for each block reads the head's link and pops the
// head once the output is free. Release and a refused or empty allocate go
// straight to the reply; an unused opcode is dropped. Format writes one link per
// cycle for the blocks from FIRST_DATA_BLOCK below min(total_blocks, MAX_BLOCKS).
// The link RAM is not cleared after reset; no request can read a link before
// format or release has written it. The user must write total_blocks only while
// the block is idle; the block itself does not enforce it.
module linked_free_block_allocator #(
  parameter int unsigned MAX_BLOCKS       = lfba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAX_RUN          = lfba_pkg::MAX_RUN_DEF,
  parameter int unsigned FIRST_DATA_BLOCK = lfba_pkg::FIRST_DATA_BLOCK_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [lfba_pkg::BLK_W-1:0]    block_number_i,
  input  wire logic [lfba_pkg::RUN_W-1:0]    how_many_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [lfba_pkg::BLK_W-1:0]    given_block_o,
  output logic      [1:0]                    status_o,
  output logic      [lfba_pkg::FREE_W-1:0]   free_left_o,
  output logic                               last_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lfba_pkg::CFG_W-1:0]    cfg_data_i
);

  import lfba_pkg::*;

  localparam int unsigned BW  = $clog2(MAX_BLOCKS);
  localparam int unsigned LW  = BW + 1;
  localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned TW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned VW  = (CW > RUN_W) ? CW : RUN_W;
  localparam int unsigned BLW = (CW > BLK_W) ? CW : BLK_W;

  localparam logic [LW-1:0] END_MARK   = '1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_BLOCKS - FIRST_DATA_BLOCK);

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     total_q, total_d;
  logic [LW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [BW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        tot_q, tot_d;
  logic [RUN_W-1:0]     left_q, left_d;
  status_e              rep_q, rep_d;

  logic                 out_valid_q, out_valid_d;
  logic [BLK_W-1:0]     given_q, given_d;
  status_e              status_q, status_d;
  logic [FREE_W-1:0]    free_q, free_d;
  logic                 last_q, last_d;

  logic                 ram_we;
  logic [BW-1:0]        ram_waddr;
  logic [LW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [BW-1:0]        ram_raddr;
  logic [LW-1:0]        ram_rdata;

  logic [TW-1:0]        eff_wide;
  logic [CW-1:0]        eff_total;
  logic [BLW-1:0]       blk_wide;
  logic                 blk_ok;
  logic                 enough;
  logic [CW-1:0]        ptr_next;
  logic                 head_end;
  logic                 out_free;
  logic                 in_take;

  lfba_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign eff_wide  = (TW'(total_q) > TW'(MAX_BLOCKS)) ? TW'(MAX_BLOCKS) : TW'(total_q);
  assign eff_total = CW'(eff_wide);
  assign blk_wide  = BLW'(block_number_i);
  assign blk_ok    = (blk_wide >= BLW'(FIRST_DATA_BLOCK)) && (blk_wide < BLW'(eff_total));
  assign enough    = (how_many_i <= RUN_W'(MAX_RUN)) && (VW'(count_q) >= VW'(how_many_i));
  assign ptr_next  = CW'(ptr_q) + CW'(1);
  assign head_end  = head_q[LW-1];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_take   = in_valid_i && (state_q == S_IDLE);

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign total_d     = cfg_valid_i ? cfg_data_i : total_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    tot_d       = tot_q;
    left_d      = left_q;
    rep_d       = rep_q;
    out_valid_d = out_valid_q && out_stall_i;
    given_d     = given_q;
    status_d    = status_q;
    free_d      = free_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = END_MARK;
    ram_re      = 1'b0;
    ram_raddr   = head_q[BW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          unique case (opcode_i)
            OP_FORMAT: begin
              tot_d = eff_total;
              ptr_d = BW'(FIRST_DATA_BLOCK);
              rep_d = ST_OK;
              if (eff_total > CW'(FIRST_DATA_BLOCK)) begin
                state_d = S_FORMAT;
              end else begin
                head_d  = END_MARK;
                count_d = '0;
                state_d = S_REPLY;
              end
            end
            OP_ALLOC: begin
              if (how_many_i == '0) begin
                rep_d   = ST_OK;
                state_d = S_REPLY;
              end else if (!enough) begin
                rep_d   = ST_NO_SPACE;
                state_d = S_REPLY;
              end else begin
                left_d  = how_many_i;
                state_d = S_POP_RD;
              end
            end
            OP_RELEASE: begin
              if (blk_ok) begin
                // push onto the head
                ram_we    = 1'b1;
                ram_waddr = BW'(blk_wide);
                ram_wdata = head_q;
                head_d    = LW'(blk_wide);
                if (count_q < FULL_COUNT) begin
                  count_d = count_q + CW'(1);
                end
                rep_d = ST_OK;
              end else begin
                rep_d = ST_RANGE;
              end
              state_d = S_REPLY;
            end
            default: begin
              // drop unused opcode
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_FORMAT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        if (ptr_next < tot_q) begin
          ram_wdata = LW'(ptr_next);
          ptr_d     = BW'(ptr_next);
        end else begin
          ram_wdata = END_MARK;
          head_d    = LW'(FIRST_DATA_BLOCK);
          count_d   = tot_q - CW'(FIRST_DATA_BLOCK);
          state_d   = S_REPLY;
        end
      end
      S_POP_RD: begin
        ram_re  = !head_end;
        state_d = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          given_d     = head_end ? '1 : BLK_W'(head_q[BW-1:0]);
          status_d    = ST_OK;
          free_d      = FREE_W'(count_q - CW'(1));
          last_d      = (left_q == RUN_W'(1));
          head_d      = head_end ? END_MARK : ram_rdata;
          count_d     = count_q - CW'(1);
          left_d      = left_q - RUN_W'(1);
          state_d     = (left_q == RUN_W'(1)) ? S_IDLE : S_POP_RD;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          given_d     = '0;
          status_d    = rep_q;
          free_d      = FREE_W'(count_q);
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= TOTAL_RESET;
      head_q      <= END_MARK;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    tot_q    <= tot_d;
    left_q   <= left_d;
    rep_q    <= rep_d;
    given_q  <= given_d;
    status_q <= status_d;
    free_q   <= free_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign given_block_o = given_q;
  assign status_o      = status_q;
  assign free_left_o   = free_q;
  assign last_o        = last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("free count above store capacity");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_OUT |-> count_q != '0)
    else $error("pop with empty free count");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(given_block_o)
      && $stable(free_left_o) && $stable(status_o) && $stable(last_o))
    else $error("pending result overwritten");

  a_last_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_OUT) && out_free && (left_q == RUN_W'(1))
      |=> (state_q == S_IDLE) && last_o && out_valid_o)
    else $error("final pop not marked or sequencer not idle");

endmodule

`default_nettype wire

[tb/tb_linked_free_block_allocator.sv]
`timescale 1ns / 1ps

module tb_linked_free_block_allocator;
  import lfba_pkg::*;

  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [12:0] END_LINK      = 13'h1FFF;
  localparam int unsigned FIRST_BLK     = FIRST_DATA_BLOCK_DEF;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned FINAL_CYCLES  = 20;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;

  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    status_e           status;
    logic [FREE_W-1:0] left;
    logic              last;
  } grant_t;

  class free_list_tracker;
    bit [CFG_W-1:0] link_mem [MAX_BLOCKS_DEF];
    bit [CFG_W-1:0] head = END_LINK;
    int unsigned    free_cnt = 0;
    int unsigned    total = TOTAL_RESET;
    grant_t         pending_grants [$];
    bit [BLK_W-1:0] handed_out [$];
    int unsigned    failures, checked, refused, rejected, formats;

    function int unsigned store_limit();
      return (total > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : total;
    endfunction

    function void set_total(bit [CFG_W-1:0] value);
      total = value;
    endfunction

    function void queue_grant(bit [BLK_W-1:0] blk, status_e st, int unsigned left, bit lst);
      pending_grants.insert(pending_grants.size(), grant_t'{blk, st, FREE_W'(left), lst});
    endfunction

    // Walk the free list exactly as the block should for one accepted request.
    function void predict_grants(bit [1:0] op, bit [BLK_W-1:0] blk, bit [RUN_W-1:0] n);
      int unsigned    lim;
      int unsigned    b;
      bit [CFG_W-1:0] got;
      lim = store_limit();
      case (op)
        OP_FORMAT: begin
          formats++;
          handed_out.delete();
          if (lim > FIRST_BLK) begin
            for (b = FIRST_BLK; b < lim; b++)
              link_mem[b] = (b + 1 < lim) ? CFG_W'(b + 1) : END_LINK;
            head = CFG_W'(FIRST_BLK);
            free_cnt = lim - FIRST_BLK;
          end else begin
            head = END_LINK;
            free_cnt = 0;
          end
          queue_grant('0, ST_OK, free_cnt, 1'b1);
        end
        OP_ALLOC: begin
          if (n == 0) begin
            queue_grant('0, ST_OK, free_cnt, 1'b1);
          end else if (n > MAX_RUN_DEF || free_cnt < n) begin
            refused++;
            queue_grant('0, ST_NO_SPACE, free_cnt, 1'b1);
          end else begin
            for (b = 0; b < n; b++) begin
              got = head;
              head = (got < MAX_BLOCKS_DEF) ? link_mem[got] : END_LINK;
              free_cnt--;
              handed_out.insert(handed_out.size(), got[BLK_W-1:0]);
              queue_grant(got[BLK_W-1:0], ST_OK, free_cnt, b + 1 == n);
            end
          end
        end
        OP_RELEASE: begin
          if (blk < FIRST_BLK || blk >= lim) begin
            rejected++;
            queue_grant('0, ST_RANGE, free_cnt, 1'b1);
          end else begin
            link_mem[blk] = head;
            head = {1'b0, blk};
            // saturate on duplicate releases
            if (free_cnt < MAX_BLOCKS_DEF - FIRST_BLK)
              free_cnt++;
            queue_grant('0, ST_OK, free_cnt, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_grant(logic [BLK_W-1:0] blk, logic [1:0] st,
                              logic [FREE_W-1:0] left, logic lst);
      grant_t want;
      checked++;
      if (pending_grants.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result: block %0d status %0d free %0d last %0b",
                   $time, blk, st, left, lst);
        return;
      end
      want = pending_grants.pop_front();
      if (blk !== want.blk || st !== want.status || left !== want.left ||
          lst !== want.last) begin
        failures++;
        if (failures <= 10)
          $display({"%0t: mismatch: expected block %0d status %s free %0d last %0b,",
                    " got block %0d status %0d free %0d last %0b"},
                   $time, want.blk, want.status.name(), want.left, want.last,
                   blk, st, left, lst);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          opcode_i;
  logic [BLK_W-1:0]    block_number_i;
  logic [RUN_W-1:0]    how_many_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [BLK_W-1:0]    given_block_o;
  logic [1:0]          status_o;
  logic [FREE_W-1:0]   free_left_o;
  logic                last_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i;

  free_list_tracker tracker = new;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned requests_sent = 0;

  int unsigned phase_total [4] = '{4096, 12, 5, 150};
  int unsigned phase_send  [4] = '{0, 48, 0, 30};
  int unsigned phase_stall [4] = '{0, 0, 48, 30};

  linked_free_block_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .block_number_i (block_number_i),
    .how_many_i     (how_many_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .given_block_o  (given_block_o),
    .status_o       (status_o),
    .free_left_o    (free_left_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Long hold-off takes priority over random stalls.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      tracker.check_grant(given_block_o, status_o, free_left_o, last_o);
  end

  // Leave valid high after acceptance so back-to-back requests need no toggle.
  task automatic send_request(bit [1:0] op, bit [BLK_W-1:0] blk, bit [RUN_W-1:0] n);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    block_number_i <= blk;
    how_many_i     <= n;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    requests_sent++;
    tracker.predict_grants(op, blk, n);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_total(bit [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    tracker.set_total(value);
  endtask

  // Mostly well-formed traffic: releases favor blocks that are actually out.
  task automatic random_request();
    bit [1:0]       op;
    bit [BLK_W-1:0] blk;
    bit [RUN_W-1:0] n;
    int unsigned    pick;
    int unsigned    lim;
    int unsigned    idx;
    pick = $urandom_range(99);
    blk  = BLK_W'($urandom);
    n    = RUN_W'($urandom);
    lim  = tracker.store_limit();
    if (pick < 4) begin
      op = OP_FORMAT;
    end else if (pick < 50) begin
      op = OP_ALLOC;
      pick = $urandom_range(99);
      if (pick < 60)      n = RUN_W'($urandom_range(1, 4));
      else if (pick < 85) n = RUN_W'($urandom_range(5, 16));
      else if (pick < 93) n = RUN_W'($urandom_range(17, MAX_RUN_DEF));
      else if (pick < 97) n = RUN_W'($urandom_range(MAX_RUN_DEF + 1, 127));
      else                n = '0;
    end else if (pick < 96) begin
      op = OP_RELEASE;
      pick = $urandom_range(99);
      if (pick < 70 && tracker.handed_out.size() > 0) begin
        idx = $urandom_range(tracker.handed_out.size() - 1);
        blk = tracker.handed_out[idx];
        tracker.handed_out.delete(idx);
      end else if (pick < 80) begin
        blk = BLK_W'($urandom_range(FIRST_BLK, lim - 1));
      end else if (pick < 90) begin
        if (pick[0] || lim >= MAX_BLOCKS_DEF)
          blk = BLK_W'($urandom_range(0, FIRST_BLK - 1));
        else
          blk = BLK_W'($urandom_range(lim, MAX_BLOCKS_DEF - 1));
      end
    end else begin
      op = OP_UNUSED;
    end
    send_request(op, blk, n);
  endtask

  initial begin
    int unsigned ph;
    int unsigned k;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_FORMAT;
    block_number_i = '0;
    how_many_i     = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unformatted store, reset size
    send_request(OP_ALLOC, 12'd0, 7'd1);
    send_request(OP_ALLOC, 12'd0, 7'd0);
    send_request(OP_RELEASE, 12'd4095, 7'd0);
    send_request(OP_RELEASE, 12'd0, 7'd0);
    send_request(OP_RELEASE, 12'd1, 7'd0);
    send_request(OP_ALLOC, 12'd0, 7'd1);
    send_request(OP_UNUSED, 12'hFFF, 7'h7F);
    send_request(OP_FORMAT, 12'd0, 7'd0);
    send_request(OP_ALLOC, 12'd0, 7'(MAX_RUN_DEF));
    send_request(OP_ALLOC, 12'd0, 7'(MAX_RUN_DEF + 1));
    send_request(OP_ALLOC, 12'd0, 7'd127);
    send_request(OP_RELEASE, 12'd2, 7'd0);
    send_request(OP_RELEASE, 12'd2, 7'd0);
    send_request(OP_ALLOC, 12'd0, 7'd2);

    // smallest store
    wait_drained();
    write_total(13'd5);
    send_request(OP_RELEASE, 12'd4, 7'd0);
    send_request(OP_RELEASE, 12'd5, 7'd0);
    send_request(OP_FORMAT, 12'd0, 7'd0);
    send_request(OP_ALLOC, 12'd0, 7'd4);
    send_request(OP_ALLOC, 12'd0, 7'd3);
    send_request(OP_RELEASE, 12'd4095, 7'd0);

    // no data blocks at all
    wait_drained();
    write_total(13'd2);
    send_request(OP_FORMAT, 12'd0, 7'd0);
    send_request(OP_ALLOC, 12'd0, 7'd1);

    // size above the store clamps; full store saturates the free count
    wait_drained();
    write_total(13'h1FFF);
    send_request(OP_FORMAT, 12'd0, 7'd0);
    send_request(OP_RELEASE, 12'd4095, 7'd0);
    send_request(OP_ALLOC, 12'd0, 7'd1);

    for (ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_total(CFG_W'(phase_total[ph]));
      send_idle_pct = phase_send[ph];
      stall_pct     = phase_stall[ph];
      // back up the output so the block stalls its input
      if (ph == 2)
        hold_left = HOLD_CYCLES;
      send_request(OP_FORMAT, BLK_W'($urandom), RUN_W'($urandom));
      for (k = 1; k < PHASE_ITEMS; k++)
        random_request();
    end

    in_valid_i <= 1'b0;
    while (tracker.pending_grants.size() != 0) @(posedge clk_i);
    repeat (FINAL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests across five store sizes and four idle mixes; %0d results checked.",
             requests_sent, tracker.checked);
    $display("Formats %0d, refused allocations %0d, out-of-range releases %0d, failures %0d.",
             tracker.formats, tracker.refused, tracker.rejected, tracker.failures);
    if (tracker.failures == 0 && tracker.pending_grants.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/core/lfba_pkg.sv
rtl/core/lfba_ram.sv
rtl/core/linked_free_block_allocator.sv
tb/tb_linked_free_block_allocator.sv
